// ===== design/sorted_store_key_count_search_macros.svh =====
// assertion macros shared by the sorted store key count search modules
// expects clk_i and rst_ni in the scope of each use
`ifndef SORTED_STORE_KEY_COUNT_SEARCH_MACROS_SVH
`define SORTED_STORE_KEY_COUNT_SEARCH_MACROS_SVH

// property that holds at every edge out of reset
`define SSKCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define SSKCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSKCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sskcs_pkg.sv =====
// types, codes and control store of the sorted store key count search
// no dependencies
package sskcs_pkg;

  localparam int DEPTH_DEF   = 1024;
  localparam int VALUE_W_DEF = 16;

  localparam int MODE_W     = 2;
  localparam int IN_VALUE_W = 16;
  localparam int FOUND_W    = 11;
  localparam int CMP_W      = 12;
  localparam int STORED_W   = 11;
  localparam int STEP_W     = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SEQ    = 2'd1,
    MODE_SORTED = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_LOAD,
    ACT_CLEAR,
    ACT_LIN_INIT,
    ACT_LIN_RD,
    ACT_LIN_STEP,
    ACT_SORT_INIT,
    ACT_SORT_ROW,
    ACT_SORT_FIRST,
    ACT_SORT_SCAN,
    ACT_SORT_SWAP1,
    ACT_SORT_SWAP2,
    ACT_BIN_INIT,
    ACT_BIN_PROBE,
    ACT_BIN_CMP,
    ACT_SPR_RDL,
    ACT_SPR_L,
    ACT_SPR_RDR,
    ACT_SPR_R,
    ACT_FINISH
  } act_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_N_ZERO,
    COND_N_LT2,
    COND_A_LT_N,
    COND_B_LT_N,
    COND_A2_LT_N,
    COND_HIT,
    COND_FL_LE,
    COND_L_LT_FIRST,
    COND_R_GT_LAST
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic n_zero;
    logic n_lt2;
    logic a_lt_n;
    logic b_lt_n;
    logic a2_lt_n;
    logic hit;
    logic fl_le;
    logic l_lt_first;
    logic r_gt_last;
  } status_t;

  localparam step_t STEP_IDLE = 5'd0;
  localparam step_t STEP_LD   = 5'd1;
  localparam step_t STEP_CLR  = 5'd2;
  localparam step_t STEP_LIN0 = 5'd3;
  localparam step_t STEP_LIN1 = 5'd4;
  localparam step_t STEP_LIN2 = 5'd5;
  localparam step_t STEP_LIN3 = 5'd6;
  localparam step_t STEP_SRT0 = 5'd7;
  localparam step_t STEP_SRT1 = 5'd8;
  localparam step_t STEP_SRT2 = 5'd9;
  localparam step_t STEP_SRT3 = 5'd10;
  localparam step_t STEP_SRT4 = 5'd11;
  localparam step_t STEP_SRT5 = 5'd12;
  localparam step_t STEP_BIN0 = 5'd13;
  localparam step_t STEP_BIN1 = 5'd14;
  localparam step_t STEP_BIN2 = 5'd15;
  localparam step_t STEP_BIN3 = 5'd16;
  localparam step_t STEP_BIN4 = 5'd17;
  localparam step_t STEP_SPL0 = 5'd18;
  localparam step_t STEP_SPL1 = 5'd19;
  localparam step_t STEP_SPR0 = 5'd20;
  localparam step_t STEP_SPR1 = 5'd21;
  localparam step_t STEP_FIN  = 5'd22;

  function automatic ctrl_t rom_word(input step_t step);
    ctrl_t w;
    w = '{act: ACT_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: w = '{act: ACT_NOP,        cond: COND_ALWAYS,     target: STEP_IDLE};
      STEP_LD:   w = '{act: ACT_LOAD,       cond: COND_ALWAYS,     target: STEP_FIN};
      STEP_CLR:  w = '{act: ACT_CLEAR,      cond: COND_ALWAYS,     target: STEP_FIN};
      STEP_LIN0: w = '{act: ACT_LIN_INIT,   cond: COND_N_ZERO,     target: STEP_FIN};
      STEP_LIN1: w = '{act: ACT_LIN_RD,     cond: COND_NEVER,      target: STEP_IDLE};
      STEP_LIN2: w = '{act: ACT_LIN_STEP,   cond: COND_A_LT_N,     target: STEP_LIN2};
      STEP_LIN3: w = '{act: ACT_NOP,        cond: COND_ALWAYS,     target: STEP_FIN};
      STEP_SRT0: w = '{act: ACT_SORT_INIT,  cond: COND_N_LT2,      target: STEP_BIN0};
      STEP_SRT1: w = '{act: ACT_SORT_ROW,   cond: COND_NEVER,      target: STEP_IDLE};
      STEP_SRT2: w = '{act: ACT_SORT_FIRST, cond: COND_NEVER,      target: STEP_IDLE};
      STEP_SRT3: w = '{act: ACT_SORT_SCAN,  cond: COND_B_LT_N,     target: STEP_SRT3};
      STEP_SRT4: w = '{act: ACT_SORT_SWAP1, cond: COND_NEVER,      target: STEP_IDLE};
      STEP_SRT5: w = '{act: ACT_SORT_SWAP2, cond: COND_A2_LT_N,    target: STEP_SRT1};
      STEP_BIN0: w = '{act: ACT_BIN_INIT,   cond: COND_N_ZERO,     target: STEP_FIN};
      STEP_BIN1: w = '{act: ACT_BIN_PROBE,  cond: COND_NEVER,      target: STEP_IDLE};
      STEP_BIN2: w = '{act: ACT_BIN_CMP,    cond: COND_HIT,        target: STEP_SPL0};
      STEP_BIN3: w = '{act: ACT_NOP,        cond: COND_FL_LE,      target: STEP_BIN1};
      STEP_BIN4: w = '{act: ACT_NOP,        cond: COND_ALWAYS,     target: STEP_FIN};
      STEP_SPL0: w = '{act: ACT_SPR_RDL,    cond: COND_L_LT_FIRST, target: STEP_SPR0};
      STEP_SPL1: w = '{act: ACT_SPR_L,      cond: COND_HIT,        target: STEP_SPL0};
      STEP_SPR0: w = '{act: ACT_SPR_RDR,    cond: COND_R_GT_LAST,  target: STEP_FIN};
      STEP_SPR1: w = '{act: ACT_SPR_R,      cond: COND_HIT,        target: STEP_SPR0};
      STEP_FIN:  w = '{act: ACT_FINISH,     cond: COND_ALWAYS,     target: STEP_IDLE};
      default:   w = '{act: ACT_NOP,        cond: COND_ALWAYS,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_t entry_step(input mode_e mode);
    step_t s;
    s = STEP_LD;
    unique case (mode)
      MODE_LOAD:   s = STEP_LD;
      MODE_SEQ:    s = STEP_LIN0;
      MODE_SORTED: s = STEP_SRT0;
      MODE_CLEAR:  s = STEP_CLR;
      default:     s = STEP_CLR;
    endcase
    return s;
  endfunction

endpackage

// ===== design/sorted_store_key_count_search.sv =====
// Sorted store key count search. A command word (mode_i, value_i) is taken when start_i is
// high and busy_o is low; exactly one result word follows on done_o, held for a single
// cycle, and the receiver cannot stall it, so it must be captured in that cycle. A new
// command may be issued in the strobe cycle. Load appends an entry, or flags overflow when
// the store is full; clear empties the store; sequential count scans every entry held; and
// sorted count runs a selection sort, then a binary search and a scan over the duplicates.
// Every read or write of an entry takes its own step of the microcode sequencer, since
// the value store is single-port, and read data is registered. The store needs no
// clearing after reset.
// depends on sskcs_pkg, sskcs_seq and sskcs_dp
module sorted_store_key_count_search
  import sskcs_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [IN_VALUE_W-1:0] value_i,
  output logic                  done_o,
  output logic [FOUND_W-1:0]    found_count_o,
  output logic [CMP_W-1:0]      comparison_count_o,
  output logic [STORED_W-1:0]   stored_count_o,
  output logic                  overflow_o
);

  act_e    act;
  status_t status;

  sskcs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .mode_i   (mode_i),
    .status_i (status),
    .act_o    (act),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  sskcs_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .act_i              (act),
    .value_i            (value_i),
    .status_o           (status),
    .found_count_o      (found_count_o),
    .comparison_count_o (comparison_count_o),
    .stored_count_o     (stored_count_o),
    .overflow_o         (overflow_o)
  );

endmodule

// ===== design/sskcs_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module sskcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sskcs_seq.sv =====
// microcode sequencer: step counter, control store lookup, jumps and result strobe
// depends on sskcs_pkg and the assertion macro header
`include "sorted_store_key_count_search_macros.svh"

module sskcs_seq
  import sskcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MODE_W-1:0] mode_i,
  input  status_t           status_i,
  output act_e              act_o,
  output logic              busy_o,
  output logic              done_o
);

  step_t upc_q, upc_d;
  logic  done_q, done_d;
  ctrl_t word;
  logic  idle;
  logic  taken;

  assign word = rom_word(upc_q);
  assign idle = (upc_q == STEP_IDLE);

  always_comb begin
    unique case (word.cond)
      COND_NEVER:      taken = 1'b0;
      COND_ALWAYS:     taken = 1'b1;
      COND_N_ZERO:     taken = status_i.n_zero;
      COND_N_LT2:      taken = status_i.n_lt2;
      COND_A_LT_N:     taken = status_i.a_lt_n;
      COND_B_LT_N:     taken = status_i.b_lt_n;
      COND_A2_LT_N:    taken = status_i.a2_lt_n;
      COND_HIT:        taken = status_i.hit;
      COND_FL_LE:      taken = status_i.fl_le;
      COND_L_LT_FIRST: taken = status_i.l_lt_first;
      COND_R_GT_LAST:  taken = status_i.r_gt_last;
      default:         taken = 1'b0;
    endcase
  end

  always_comb begin
    if (idle) begin
      act_o = start_i ? ACT_ACCEPT : ACT_NOP;
      upc_d = start_i ? entry_step(mode_e'(mode_i)) : STEP_IDLE;
    end else begin
      act_o = word.act;
      upc_d = taken ? word.target : upc_q + step_t'(1);
    end
    done_d = !idle && (word.act == ACT_FINISH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= STEP_IDLE;
      done_q <= 1'b0;
    end else begin
      upc_q  <= upc_d;
      done_q <= done_d;
    end
  end

  assign busy_o = !idle;
  assign done_o = done_q;

  `SSKCS_ASSERT_NEXT(a_accept_busy, start_i && idle, busy_o, "accepted word did not start")
  `SSKCS_ASSERT_IMP(a_done_idle, done_o, !busy_o, "result strobe while busy")
  `SSKCS_ASSERT(a_upc_range, upc_q <= STEP_FIN, "step counter outside control store")

endmodule

// ===== design/sskcs_dp.sv =====
// datapath: entry count, index registers, counters and the value store
// depends on sskcs_pkg, sskcs_ram and the assertion macro header
`include "sorted_store_key_count_search_macros.svh"

module sskcs_dp
  import sskcs_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  act_e                  act_i,
  input  logic [IN_VALUE_W-1:0] value_i,
  output status_t               status_o,
  output logic [FOUND_W-1:0]    found_count_o,
  output logic [CMP_W-1:0]      comparison_count_o,
  output logic [STORED_W-1:0]   stored_count_o,
  output logic                  overflow_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int SW = CW + 1;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] found_q, found_d;
  logic [SW-1:0] cmps_q, cmps_d;
  logic          ovf_q, ovf_d;

  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic [VALUE_WIDTH-1:0] av_q, av_d;
  logic [VALUE_WIDTH-1:0] lov_q, lov_d;
  logic [CW-1:0]          a_q, a_d;
  logic [CW-1:0]          b_q, b_d;
  logic [AW-1:0]          lo_q, lo_d;
  logic [SW-1:0]          first_q, first_d;
  logic [SW-1:0]          last_q, last_d;
  logic [SW-1:0]          mid_q, mid_d;
  logic [SW-1:0]          l_q, l_d;
  logic [SW-1:0]          r_q, r_d;

  logic                   ram_en;
  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [VALUE_WIDTH-1:0] rdata;

  logic [SW:0]   mid_sum;
  logic [SW-1:0] mid_c;
  logic [CW-1:0] b_m1;
  logic [SW-1:0] a_p2;
  logic          n_full;
  logic          hit;
  logic          rd_lt_key;
  logic          rd_lt_lov;

  assign mid_sum   = {first_q[SW-1], first_q} + {last_q[SW-1], last_q};
  assign mid_c     = mid_sum[SW:1];
  assign b_m1      = b_q - CW'(1);
  assign a_p2      = {1'b0, a_q} + SW'(2);
  assign n_full    = (cnt_q == CW'(DEPTH));
  assign hit       = (rdata == key_q);
  assign rd_lt_key = (rdata < key_q);
  assign rd_lt_lov = (rdata < lov_q);

  always_comb begin
    status_o.n_zero     = (cnt_q == '0);
    status_o.n_lt2      = (cnt_q < CW'(2));
    status_o.a_lt_n     = (a_q < cnt_q);
    status_o.b_lt_n     = (b_q < cnt_q);
    status_o.a2_lt_n    = (a_p2 < {1'b0, cnt_q});
    status_o.hit        = hit;
    status_o.fl_le      = ($signed(first_q) <= $signed(last_q));
    status_o.l_lt_first = ($signed(l_q) < $signed(first_q));
    status_o.r_gt_last  = ($signed(r_q) > $signed(last_q));
  end

  always_comb begin
    cnt_d     = cnt_q;
    found_d   = found_q;
    cmps_d    = cmps_q;
    ovf_d     = ovf_q;
    key_d     = key_q;
    av_d      = av_q;
    lov_d     = lov_q;
    a_d       = a_q;
    b_d       = b_q;
    lo_d      = lo_q;
    first_d   = first_q;
    last_d    = last_q;
    mid_d     = mid_q;
    l_d       = l_q;
    r_d       = r_q;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = key_q;
    unique case (act_i)
      ACT_ACCEPT: begin
        key_d   = VALUE_WIDTH'(value_i);
        found_d = '0;
        cmps_d  = '0;
        ovf_d   = 1'b0;
      end
      ACT_LOAD: begin
        if (n_full) begin
          ovf_d = 1'b1;
        end else begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_addr  = cnt_q[AW-1:0];
          ram_wdata = key_q;
          cnt_d     = cnt_q + CW'(1);
        end
      end
      ACT_CLEAR: begin
        cnt_d = '0;
      end
      ACT_LIN_INIT: begin
        cmps_d = {1'b0, cnt_q};
        a_d    = '0;
      end
      ACT_LIN_RD: begin
        ram_en   = 1'b1;
        ram_addr = a_q[AW-1:0];
        a_d      = a_q + CW'(1);
      end
      ACT_LIN_STEP: begin
        if (hit) begin
          found_d = found_q + CW'(1);
        end
        if (status_o.a_lt_n) begin
          ram_en   = 1'b1;
          ram_addr = a_q[AW-1:0];
          a_d      = a_q + CW'(1);
        end
      end
      ACT_SORT_INIT: begin
        a_d = '0;
      end
      ACT_SORT_ROW: begin
        ram_en   = 1'b1;
        ram_addr = a_q[AW-1:0];
        lo_d     = a_q[AW-1:0];
        b_d      = a_q + CW'(1);
      end
      ACT_SORT_FIRST: begin
        av_d     = rdata;
        lov_d    = rdata;
        ram_en   = 1'b1;
        ram_addr = b_q[AW-1:0];
        b_d      = b_q + CW'(1);
      end
      ACT_SORT_SCAN: begin
        if (rd_lt_lov) begin
          lo_d  = b_m1[AW-1:0];
          lov_d = rdata;
        end
        if (status_o.b_lt_n) begin
          ram_en   = 1'b1;
          ram_addr = b_q[AW-1:0];
          b_d      = b_q + CW'(1);
        end
      end
      ACT_SORT_SWAP1: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = lo_q;
        ram_wdata = av_q;
      end
      ACT_SORT_SWAP2: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = a_q[AW-1:0];
        ram_wdata = lov_q;
        a_d       = a_q + CW'(1);
      end
      ACT_BIN_INIT: begin
        first_d = '0;
        last_d  = {1'b0, cnt_q} - SW'(1);
      end
      ACT_BIN_PROBE: begin
        mid_d    = mid_c;
        ram_en   = 1'b1;
        ram_addr = mid_c[AW-1:0];
        cmps_d   = cmps_q + SW'(1);
      end
      ACT_BIN_CMP: begin
        if (hit) begin
          found_d = CW'(1);
          l_d     = mid_q - SW'(1);
          r_d     = mid_q + SW'(1);
        end else if (rd_lt_key) begin
          first_d = mid_q + SW'(1);
        end else begin
          last_d = mid_q - SW'(1);
        end
      end
      ACT_SPR_RDL: begin
        ram_en   = !status_o.l_lt_first;
        ram_addr = l_q[AW-1:0];
      end
      ACT_SPR_L: begin
        if (hit) begin
          found_d = found_q + CW'(1);
          cmps_d  = cmps_q + SW'(1);
          l_d     = l_q - SW'(1);
        end
      end
      ACT_SPR_RDR: begin
        ram_en   = !status_o.r_gt_last;
        ram_addr = r_q[AW-1:0];
      end
      ACT_SPR_R: begin
        if (hit) begin
          found_d = found_q + CW'(1);
          cmps_d  = cmps_q + SW'(1);
          r_d     = r_q + SW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      found_q <= '0;
      cmps_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      found_q <= found_d;
      cmps_q  <= cmps_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    av_q    <= av_d;
    lov_q   <= lov_d;
    a_q     <= a_d;
    b_q     <= b_d;
    lo_q    <= lo_d;
    first_q <= first_d;
    last_q  <= last_d;
    mid_q   <= mid_d;
    l_q     <= l_d;
    r_q     <= r_d;
  end

  sskcs_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rdata)
  );

  assign found_count_o      = FOUND_W'(found_q);
  assign comparison_count_o = CMP_W'(cmps_q);
  assign stored_count_o     = STORED_W'(cnt_q);
  assign overflow_o         = ovf_q;

  `SSKCS_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "entry count beyond store depth")
  `SSKCS_ASSERT_IMP(a_ovf_full, ovf_q, n_full, "overflow flagged with room in store")

endmodule
